FILE: src/ksat_pkg.sv
// ============================================================================
// ksat_pkg
// Types, constants and per-key update functions for the key state tracker.
// ============================================================================
`default_nettype none

package ksat_pkg;

   localparam int KEYS        = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int KEY_W       = $clog2(KEYS);
   localparam int QI_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [16:0] REPEAT_DEFAULT = 17'sd200;
   localparam logic signed [16:0] REPEAT_OFF     = -17'sd1;
   localparam logic signed [31:0] HOLD_MAX       = 32'sh7FFF_FFFF;

   typedef enum logic [2:0] {
      OP_KEY_DOWN  = 3'd0,
      OP_KEY_UP    = 3'd1,
      OP_LOST_FOC  = 3'd2,
      OP_TICK      = 3'd3,
      OP_MOUSE_POS = 3'd4,
      OP_SET_REP   = 3'd5,
      OP_READ_KEY  = 3'd6,
      OP_NOP       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      REG_ALTGR   = 2'd0,
      REG_LCTRL   = 2'd1,
      REG_FIX_EN  = 2'd2,
      REG_NONE    = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_KRD,
      S_KWR,
      S_LRD,
      S_LWR,
      S_WALK,
      S_WEND,
      S_FRD,
      S_FIN
   } state_type;

   typedef struct packed {
      logic                    down;
      logic signed [31:0]      hold;
      logic signed [16:0]      rep;
      logic [QUEUE_DEPTH-1:0]  ev;
      logic [QC_W-1:0]         cnt;
   } entry_type;

   function automatic entry_type reset_entry(input logic [KEY_W-1:0] idx);
      entry_type e;
      e      = '0;
      e.rep  = REPEAT_DEFAULT;
      if (idx == KEY_W'(1) || idx == KEY_W'(2) || idx == KEY_W'(4)) begin
         e.rep = REPEAT_OFF;
      end
      return e;
   endfunction

   function automatic logic eff_down(input entry_type e);
      logic [QC_W-1:0] m;
      m = e.cnt - QC_W'(1);
      if (e.cnt == '0) begin
         return e.down;
      end
      return e.ev[m[QI_W-1:0]];
   endfunction

   function automatic logic q_full(input entry_type e);
      return e.cnt >= QC_W'(QUEUE_DEPTH);
   endfunction

   function automatic entry_type q_push(input entry_type e, input logic d);
      entry_type r;
      r = e;
      if (!q_full(e)) begin
         r.ev[e.cnt[QI_W-1:0]] = d;
         r.cnt = e.cnt + QC_W'(1);
      end
      return r;
   endfunction

   function automatic entry_type tick_entry(input entry_type e, input logic [15:0] delta);
      entry_type r;
      logic signed [32:0] s;
      r = e;
      if (e.cnt != '0) begin
         r.down = e.ev[0];
         r.ev   = e.ev >> 1;
         r.cnt  = e.cnt - QC_W'(1);
      end
      s = {e.hold[31], e.hold} + {17'b0, delta};
      if (r.down) begin
         if (e.hold > 32'sd0) begin
            if (s > {1'b0, HOLD_MAX}) begin
               s = {1'b0, HOLD_MAX};
            end
            if (s == 33'sd1) begin
               s = 33'sd2;
            end
            if (!e.rep[16] && s > {{16{e.rep[16]}}, e.rep}) begin
               s = 33'sd1;
            end
            r.hold = s[31:0];
         end else begin
            r.hold = 32'sd1;
         end
      end else begin
         r.hold = (e.hold > 32'sd0) ? -e.hold : 32'sd0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/ksat_store.sv
// ============================================================================
// ksat_store
// Per-key state memory with one read and one write port and reset view bits.
// ============================================================================
`default_nettype none

module ksat_store
   import ksat_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [KEY_W-1:0] rd_addr,
   input  wire logic             wr_en,
   input  wire logic [KEY_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   output entry_type             rd_data,
   output logic [KEY_W-1:0]      rd_addr_q
);

   entry_type        mem [KEYS];
   entry_type        rd_raw_ff;
   logic [KEYS-1:0]  valid_ff;
   logic             rd_vld_ff;
   logic [KEY_W-1:0] rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_raw_ff  <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data   = rd_vld_ff ? rd_raw_ff : reset_entry(rd_addr_ff);
   assign rd_addr_q = rd_addr_ff;

endmodule

`default_nettype wire

FILE: src/key_state_autorepeat_tracker.sv
// ============================================================================
// key_state_autorepeat_tracker
// Per-key press state, hold time and pending transition queues.
// ============================================================================
//  Channel   Direction  Contents
//  req_      in         opcode, key_index, tick_delta, mouse_position, repeat_value
//  rsp_      out        key_value, key_is_down, mouse_x, mouse_y, queue_overflow
//  csr_      in/out     altgr_key, lctrl_key, altgr_fix_enable
//
// Key events, set_repeat, read_key and mouse requests pass S_KRD, S_KWR, S_FRD
// and S_FIN, plus S_LRD and S_LWR when the AltGr press also clears the left
// control queue. Tick and lost focus walk the key memory one entry per cycle
// through its single read and write port. Reset is synchronous; the key memory
// reads as its reset values until each entry is first written, so no clearing
// pass is needed. A stalled response holds the block in its final state.
`default_nettype none

module key_state_autorepeat_tracker
   import ksat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[2:0], key_index[10:3], tick_delta[26:11], mouse_position[58:27],
   // repeat_value[75:59], zero[79:76]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // key_value[31:0], key_is_down[32], mouse_x[48:33], mouse_y[64:49],
   // queue_overflow[65], zero[71:66]
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [7:0]         key_ff;
   logic [15:0]        delta_ff;
   logic signed [16:0] rep_ff;
   logic               ovf_ff, ovf_in;
   logic [15:0]        mx_ff, my_ff;
   logic [KEY_W-1:0]   idx_ff;
   logic [7:0]         altgr_ff, lctrl_ff;
   logic               fix_ff;
   logic               rsp_valid_ff;
   logic [71:0]        rsp_data_ff;

   logic               req_acc, rsp_free, key_ok, lctrl_ok, flush;
   logic [KEY_W-1:0]   kidx, rd_addr, wr_addr, rd_addr_q;
   logic               wr_en;
   entry_type          wr_data, rd_data, ke;
   logic               kdown, edown;
   reg_type            csr_reg;

   assign csr_pready = 1'b1;
   assign csr_reg    = reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         altgr_ff <= '0;
         lctrl_ff <= '0;
         fix_ff   <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_reg)
            REG_ALTGR:  altgr_ff <= csr_pwdata[7:0];
            REG_LCTRL:  lctrl_ff <= csr_pwdata[7:0];
            REG_FIX_EN: fix_ff   <= csr_pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_ALTGR:  csr_prdata = {24'b0, altgr_ff};
         REG_LCTRL:  csr_prdata = {24'b0, lctrl_ff};
         REG_FIX_EN: csr_prdata = {31'b0, fix_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign key_ok   = 32'(key_ff) < KEYS;
   assign lctrl_ok = 32'(lctrl_ff) < KEYS;
   assign kidx     = KEY_W'(key_ff);

   ksat_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .rd_addr_q (rd_addr_q)
   );

   assign kdown = eff_down(rd_data);
   assign edown = (op_ff == OP_KEY_DOWN);
   assign flush = fix_ff && edown && !kdown && key_ff == altgr_ff && lctrl_ok;

   always_comb begin
      ke = rd_data;
      if (!(kdown && edown)) begin
         if (!kdown && !edown) begin
            ke = q_push(ke, 1'b1);
         end
         ke = q_push(ke, edown);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tdata[2:0] == OP_LOST_FOC || req_tdata[2:0] == OP_TICK) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_KRD;
               end
            end
         end
         S_KRD:  state_in = S_KWR;
         S_KWR: begin
            if ((op_ff == OP_KEY_DOWN || op_ff == OP_KEY_UP) && key_ok && flush) begin
               state_in = S_LRD;
            end else begin
               state_in = S_FRD;
            end
         end
         S_LRD:  state_in = S_LWR;
         S_LWR:  state_in = S_FRD;
         S_WALK: begin
            if (idx_ff == KEY_W'(KEYS - 1)) begin
               state_in = S_WEND;
            end
         end
         S_WEND: state_in = S_FRD;
         S_FRD:  state_in = S_FIN;
         S_FIN: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rd_addr    = kidx;
      wr_en      = 1'b0;
      wr_addr    = rd_addr_q;
      wr_data    = rd_data;
      ovf_in     = ovf_ff;
      if (state_ff == S_IDLE && req_tvalid) begin
         ovf_in = 1'b0;
      end
      case (state_ff)
         S_KWR: begin
            if (key_ok) begin
               if (op_ff == OP_KEY_DOWN || op_ff == OP_KEY_UP) begin
                  wr_en = 1'b1;
                  wr_data = ke;
                  if (!(kdown && edown)) begin
                     ovf_in = ovf_ff || q_full(rd_data) ||
                              (!kdown && !edown && q_full(q_push(rd_data, 1'b1)));
                  end
               end else if (op_ff == OP_SET_REP) begin
                  wr_en = 1'b1;
                  wr_data.rep = rep_ff;
               end
            end
         end
         S_LRD: rd_addr = KEY_W'(lctrl_ff);
         S_LWR: begin
            wr_en       = 1'b1;
            wr_data.cnt = '0;
            wr_data.ev  = '0;
         end
         S_WALK, S_WEND: begin
            if (state_ff == S_WALK) begin
               rd_addr = idx_ff;
            end
            wr_en = (state_ff == S_WEND) || (idx_ff != '0);
            if (op_ff == OP_TICK) begin
               wr_data = tick_entry(rd_data, delta_ff);
            end else if (eff_down(rd_data)) begin
               wr_data = q_push(rd_data, 1'b0);
               ovf_in  = ovf_ff || (wr_en && q_full(rd_data));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mx_ff        <= '0;
         my_ff        <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
         if (state_ff == S_WALK) begin
            idx_ff <= idx_ff + KEY_W'(1);
         end
         if (req_acc) begin
            idx_ff <= '0;
            if (req_tdata[2:0] == OP_MOUSE_POS) begin
               mx_ff <= req_tdata[42:27];
               my_ff <= req_tdata[58:43];
            end
         end
         if (state_ff == S_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff    <= op_type'(req_tdata[2:0]);
         key_ff   <= req_tdata[10:3];
         delta_ff <= req_tdata[26:11];
         rep_ff   <= req_tdata[75:59];
      end
      if (state_ff == S_FIN && rsp_free) begin
         rsp_data_ff <= {6'b0, ovf_ff, my_ff, mx_ff, key_ok && rd_data.down,
                         (op_ff == OP_READ_KEY && key_ok) ? rd_data.hold : 32'sd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_wr_states : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_KWR || state_ff == S_LWR || state_ff == S_WALK ||
                 state_ff == S_WEND))
      else $error("write outside an update state");

   a_walk_lag : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && idx_ff != '0) |-> rd_addr_q == idx_ff - KEY_W'(1))
      else $error("walk write address is not one behind the read");

   a_accept_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != S_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_flush_after_key : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LRD |-> $past(state_ff) == S_KWR)
      else $error("flush read without a preceding key write");

endmodule

`default_nettype wire
